// ===== rtl/mef_pkg.sv =====
// Shared types, register indexes and codes for the mouse event filter.
`timescale 1ns / 1ps
`default_nettype none

package mef_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_FILTER_FLAGS   = 3'd0;
    localparam logic [2:0] CFG_INTEREST_MASK  = 3'd1;
    localparam logic [2:0] CFG_BLOCK_MASK     = 3'd2;
    localparam logic [2:0] CFG_INJECT_V_READY = 3'd3;
    localparam logic [2:0] CFG_INJECT_H_READY = 3'd4;
    localparam logic [2:0] CFG_RECENT_WINDOW  = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] RECENT_WINDOW_RESET = 16'd80;

    // Bit positions inside filter_flags
    localparam int FLAG_INTERCEPT = 0;
    localparam int FLAG_VINV      = 1;
    localparam int FLAG_HINV      = 2;
    localparam int FLAG_DEBUG     = 3;

    // Item kinds
    localparam logic [1:0] KIND_MOUSE  = 2'd0;
    localparam logic [1:0] KIND_MARK   = 2'd1;
    localparam logic [1:0] KIND_TAKE_V = 2'd2;
    localparam logic [1:0] KIND_TAKE_H = 2'd3;

    // Message types
    localparam logic [2:0] MSG_MOVE     = 3'd0;
    localparam logic [2:0] MSG_WHEEL    = 3'd1;
    localparam logic [2:0] MSG_HWHEEL   = 3'd2;
    localparam logic [2:0] MSG_XDOWN    = 3'd3;
    localparam logic [2:0] MSG_XUP      = 3'd4;
    localparam logic [2:0] MSG_MID_DOWN = 3'd5;
    localparam logic [2:0] MSG_MID_UP   = 3'd6;
    localparam logic [2:0] MSG_OTHER    = 3'd7;

    // Event codes
    localparam logic [3:0] EV_NONE         = 4'd0;
    localparam logic [3:0] EV_X1_DOWN      = 4'd1;
    localparam logic [3:0] EV_X1_UP        = 4'd2;
    localparam logic [3:0] EV_X2_DOWN      = 4'd3;
    localparam logic [3:0] EV_X2_UP        = 4'd4;
    localparam logic [3:0] EV_MID_DOWN     = 4'd5;
    localparam logic [3:0] EV_MID_UP       = 4'd6;
    localparam logic [3:0] EV_SCROLL_LEFT  = 4'd7;
    localparam logic [3:0] EV_SCROLL_RIGHT = 4'd8;

    // Injector wake codes
    localparam logic [1:0] WAKE_NONE = 2'd0;
    localparam logic [1:0] WAKE_V    = 2'd1;
    localparam logic [1:0] WAKE_H    = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  message_type;
        logic [31:0] msg_data;
        logic [31:0] hook_flags;
        logic [63:0] opaque_word;
        logic [31:0] now_ms;
        logic        post_ok;
    } mef_item_t;

    typedef struct packed {
        logic               swallow;
        logic               report_valid;
        logic [3:0]         ev_code;
        logic               report_blocked;
        logic [2:0]         report_message;
        logic [31:0]        report_data;
        logic [31:0]        report_flags;
        logic [63:0]        report_extra;
        logic [1:0]         wake_injector;
        logic signed [31:0] pending_delta;
    } mef_result_t;

    typedef struct packed {
        logic [3:0]  filter_flags;
        logic [8:0]  report_mask;
        logic [8:0]  swallow_mask;
        logic        inject_v_ready;
        logic        inject_h_ready;
        logic [15:0] recent_window;
    } mef_cfg_t;

    typedef struct packed {
        logic [2:0]  held_presses;
        logic [31:0] pending_v;
        logic [31:0] pending_h;
        logic        v_posted;
        logic        h_posted;
        logic        mark_valid;
        logic [31:0] mark_time;
    } mef_state_t;

endpackage

`default_nettype wire

// ===== rtl/mef_if.sv =====
// Channel interfaces: mouse items in, filter results out, configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface mef_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  message_type;
    logic [31:0] msg_data;
    logic [31:0] hook_flags;
    logic [63:0] opaque_word;
    logic [31:0] now_ms;
    logic        post_ok;

    modport source (output valid, kind, message_type, msg_data, hook_flags,
                    opaque_word, now_ms, post_ok, input ready);
    modport sink   (input valid, kind, message_type, msg_data, hook_flags,
                    opaque_word, now_ms, post_ok, output ready);
endinterface

interface mef_result_if;
    logic               valid;
    logic               ready;
    logic               swallow;
    logic               report_valid;
    logic [3:0]         ev_code;
    logic               report_blocked;
    logic [2:0]         report_message;
    logic [31:0]        report_data;
    logic [31:0]        report_flags;
    logic [63:0]        report_extra;
    logic [1:0]         wake_injector;
    logic signed [31:0] pending_delta;

    modport source (output valid, swallow, report_valid, ev_code, report_blocked,
                    report_message, report_data, report_flags, report_extra,
                    wake_injector, pending_delta, input ready);
    modport sink   (input valid, swallow, report_valid, ev_code, report_blocked,
                    report_message, report_data, report_flags, report_extra,
                    wake_injector, pending_delta, output ready);
endinterface

interface mef_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mef_cfg_regs.sv =====
// Configuration register file of the mouse event filter.
`timescale 1ns / 1ps
`default_nettype none

module mef_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [mef_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [mef_pkg::CFG_DATA_W-1:0]  wr_data,
    output mef_pkg::mef_cfg_t                  cfg
);
    import mef_pkg::*;

    mef_cfg_t cfg_reg;
    mef_cfg_t cfg_next;

    // Decode the write onto the addressed register; drop writes beyond the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_FILTER_FLAGS:   cfg_next.filter_flags   = wr_data[3:0];
                CFG_INTEREST_MASK:  cfg_next.report_mask    = wr_data[8:0];
                CFG_BLOCK_MASK:     cfg_next.swallow_mask   = wr_data[8:0];
                CFG_INJECT_V_READY: cfg_next.inject_v_ready = wr_data[0];
                CFG_INJECT_H_READY: cfg_next.inject_h_ready = wr_data[0];
                CFG_RECENT_WINDOW:  cfg_next.recent_window  = wr_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_flags   <= '0;
            cfg_reg.report_mask    <= '0;
            cfg_reg.swallow_mask   <= '0;
            cfg_reg.inject_v_ready <= 1'b0;
            cfg_reg.inject_h_ready <= 1'b0;
            cfg_reg.recent_window  <= RECENT_WINDOW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/mef_decide.sv =====
// Single-pass decision logic: classify, swallow or pass, invert wheel, next state.
`timescale 1ns / 1ps
`default_nettype none

module mef_decide (
    input  wire mef_pkg::mef_item_t  item,
    input  wire mef_pkg::mef_cfg_t   cfg,
    input  wire mef_pkg::mef_state_t st,
    output mef_pkg::mef_result_t res,
    output mef_pkg::mef_state_t  st_next
);
    import mef_pkg::*;

    logic signed [15:0] delta16;
    logic [31:0]        delta32;
    logic [31:0]        elapsed;
    logic               recent;
    logic               is_vert;
    logic               is_scroll;
    logic               axis_ready;
    logic               axis_posted;
    logic               inv_ok;
    logic               intercept;
    logic               vinv;
    logic               hinv;
    logic               debug;
    logic               scroll_work;
    logic [3:0]         code;
    logic               block_hit;
    logic [3:0]         code_m1;
    logic [2:0]         held_bit;
    logic               is_press;
    logic               is_release;
    logic               do_invert;
    logic               do_report;
    logic [3:0]         rep_code;
    logic               rep_blk;

    // Flags and wheel delta
    assign intercept = cfg.filter_flags[FLAG_INTERCEPT];
    assign vinv      = cfg.filter_flags[FLAG_VINV];
    assign hinv      = cfg.filter_flags[FLAG_HINV];
    assign debug     = cfg.filter_flags[FLAG_DEBUG];
    assign delta16   = item.msg_data[31:16];
    assign delta32   = {{16{delta16[15]}}, delta16};

    // Recent-wheel window test, wrapping tick difference
    assign elapsed = item.now_ms - st.mark_time;
    assign recent  = st.mark_valid && (elapsed <= {16'd0, cfg.recent_window});

    // Axis selection for inversion
    assign is_vert     = (item.message_type == MSG_WHEEL);
    assign is_scroll   = is_vert || (item.message_type == MSG_HWHEEL);
    assign axis_ready  = is_vert ? cfg.inject_v_ready : cfg.inject_h_ready;
    assign axis_posted = is_vert ? st.v_posted : st.h_posted;
    assign inv_ok      = (delta16 != 16'sd0) && axis_ready && (axis_posted || item.post_ok);
    assign scroll_work = vinv || hinv ||
                         (intercept && (cfg.report_mask[8:7] != 2'b00));

    // Classify the message into an event code
    always_comb
    begin
        unique case (item.message_type)
            MSG_XDOWN:
                code = (delta16 == 16'sd1) ? EV_X1_DOWN :
                       (delta16 == 16'sd2) ? EV_X2_DOWN : EV_NONE;
            MSG_XUP:
                code = (delta16 == 16'sd1) ? EV_X1_UP :
                       (delta16 == 16'sd2) ? EV_X2_UP : EV_NONE;
            MSG_MID_DOWN: code = EV_MID_DOWN;
            MSG_MID_UP:   code = EV_MID_UP;
            MSG_HWHEEL:
                code = (delta16 > 16'sd0) ? EV_SCROLL_LEFT :
                       (delta16 < 16'sd0) ? EV_SCROLL_RIGHT : EV_NONE;
            MSG_MOVE, MSG_WHEEL, MSG_OTHER: code = EV_NONE;
            default:      code = EV_NONE;
        endcase
    end

    assign block_hit  = (code != EV_NONE) && cfg.swallow_mask[code];
    assign code_m1    = code - 4'd1;
    assign held_bit   = 3'(3'b001 << code_m1[2:1]);
    assign is_press   = (code == EV_X1_DOWN) || (code == EV_X2_DOWN) || (code == EV_MID_DOWN);
    assign is_release = (code == EV_X1_UP) || (code == EV_X2_UP) || (code == EV_MID_UP);

    // Decide the fate of the transaction and the next state
    always_comb
    begin
        st_next   = st;
        res       = '0;
        do_invert = 1'b0;
        do_report = 1'b0;
        rep_code  = EV_NONE;
        rep_blk   = 1'b0;

        unique case (item.kind)
            KIND_MARK:
            begin
                st_next.mark_valid = 1'b1;
                st_next.mark_time  = item.now_ms;
            end
            KIND_TAKE_V:
            begin
                res.pending_delta = signed'(st.pending_v);
                st_next.pending_v = '0;
                st_next.v_posted  = 1'b0;
            end
            KIND_TAKE_H:
            begin
                res.pending_delta = signed'(st.pending_h);
                st_next.pending_h = '0;
                st_next.h_posted  = 1'b0;
            end
            KIND_MOUSE:
            begin
                if ((item.message_type == MSG_MOVE) ||
                    (is_scroll && !scroll_work && !debug) ||
                    item.hook_flags[0])
                begin
                    // pass silently
                end
                else if (!intercept)
                begin
                    if (((is_vert && vinv) || (item.message_type == MSG_HWHEEL && hinv)) &&
                        recent && inv_ok)
                        do_invert = 1'b1;
                    else
                        do_report = debug;
                end
                else if (is_vert)
                begin
                    if (vinv && recent && inv_ok)
                        do_invert = 1'b1;
                    else
                        do_report = debug;
                end
                else if ((item.message_type == MSG_HWHEEL) && !block_hit && hinv &&
                         recent && inv_ok)
                begin
                    do_invert = 1'b1;
                end
                else if (code == EV_NONE)
                begin
                    do_report = debug;
                end
                else
                begin
                    // Pair a swallowed release with its swallowed press
                    if (is_press)
                    begin
                        if (block_hit)
                            st_next.held_presses = st.held_presses | held_bit;
                        rep_blk = block_hit;
                    end
                    else if (is_release)
                    begin
                        st_next.held_presses = st.held_presses & ~held_bit;
                        rep_blk = block_hit && ((st.held_presses & held_bit) != 3'b000);
                    end
                    else
                    begin
                        rep_blk = block_hit;
                    end
                    rep_code    = code;
                    do_report   = cfg.report_mask[code] || debug;
                    res.swallow = rep_blk;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase

        // Fold the negated delta into the axis sum, wake the injector once
        if (do_invert)
        begin
            res.swallow = 1'b1;
            if (is_vert)
            begin
                st_next.pending_v = st.pending_v - delta32;
                if (!st.v_posted)
                begin
                    st_next.v_posted  = 1'b1;
                    res.wake_injector = WAKE_V;
                end
            end
            else
            begin
                st_next.pending_h = st.pending_h - delta32;
                if (!st.h_posted)
                begin
                    st_next.h_posted  = 1'b1;
                    res.wake_injector = WAKE_H;
                end
            end
        end

        // Build the event report
        if (do_report)
        begin
            res.report_valid   = 1'b1;
            res.ev_code        = rep_code;
            res.report_blocked = rep_blk;
            res.report_message = item.message_type;
            res.report_data    = item.msg_data;
            res.report_flags   = item.hook_flags;
            res.report_extra   = item.opaque_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mouse_event_filter.sv =====
// Top level of the mouse event filter: input register, decision, result register.
//
//   channel | role  | moves
//   --------+-------+-----------------------------------------------
//   mouse   | sink  | one item: kind, message, data, flags, tick
//   result  | source| one result: swallow, report, wake, pending sum
//   cfg     | sink  | one register write: index, data
//
// A result is valid once the result register has loaded it: the item sits in the
// input register while the decision logic works on it, and the result
// register loads when the result channel is free. One item a cycle is sustained
// while results are not stalled; the state registers update as an item moves into
// the result register, so the next item sees them at once.
// A stalled result holds the result register; the input register still takes
// one more item. Reset clears state and both valids and resets the configuration.
`timescale 1ns / 1ps
`default_nettype none

module mouse_event_filter (
    input wire logic     clk,
    input wire logic     rst_n,
    mef_item_if.sink     mouse,
    mef_result_if.source result,
    mef_cfg_if.sink      cfg
);
    import mef_pkg::*;

    mef_cfg_t    cfg_vals;
    mef_item_t   in_data_reg;
    logic        in_valid_reg;
    mef_state_t  st_reg;
    mef_state_t  st_next;
    mef_result_t res_next;
    mef_result_t out_data_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        mouse_fire;

    // Configuration registers
    assign cfg.ready = 1'b1;

    mef_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_vals)
    );

    // Handshake control
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign mouse.ready = !in_valid_reg || advance;
    assign mouse_fire = mouse.valid && mouse.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (mouse.ready)
            in_valid_reg <= mouse.valid;
    end

    always_ff @(posedge clk)
    begin
        if (mouse_fire)
        begin
            in_data_reg.kind         <= mouse.kind;
            in_data_reg.message_type <= mouse.message_type;
            in_data_reg.msg_data     <= mouse.msg_data;
            in_data_reg.hook_flags   <= mouse.hook_flags;
            in_data_reg.opaque_word  <= mouse.opaque_word;
            in_data_reg.now_ms       <= mouse.now_ms;
            in_data_reg.post_ok      <= mouse.post_ok;
        end
    end

    // Decision logic
    mef_decide u_decide (
        .item    (in_data_reg),
        .cfg     (cfg_vals),
        .st      (st_reg),
        .res     (res_next),
        .st_next (st_next)
    );

    // Filter state, updated as each transaction is decided
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (advance)
            st_reg <= st_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= res_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.swallow        = out_data_reg.swallow;
    assign result.report_valid   = out_data_reg.report_valid;
    assign result.ev_code        = out_data_reg.ev_code;
    assign result.report_blocked = out_data_reg.report_blocked;
    assign result.report_message = out_data_reg.report_message;
    assign result.report_data    = out_data_reg.report_data;
    assign result.report_flags   = out_data_reg.report_flags;
    assign result.report_extra   = out_data_reg.report_extra;
    assign result.wake_injector  = out_data_reg.wake_injector;
    assign result.pending_delta  = out_data_reg.pending_delta;

endmodule

`default_nettype wire

// ===== rtl/mef_checker.sv =====
// Port-level checks for the mouse event filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mef_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        swallow,
    input wire logic        report_valid,
    input wire logic [3:0]  ev_code,
    input wire logic        report_blocked,
    input wire logic [1:0]  wake_injector,
    input wire logic [31:0] pending_delta
);
    import mef_pkg::*;

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(swallow) &&
        $stable(wake_injector) && $stable(pending_delta) && $stable(ev_code))
        else $error("stalled result changed");

    // Empty report fields without a report
    a_no_report_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !report_valid |-> ev_code == EV_NONE && !report_blocked)
        else $error("report fields set without a report");

    // A wake comes only from an inverted, swallowed wheel message
    a_wake_swallows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && wake_injector != WAKE_NONE |->
        swallow && !report_valid && pending_delta == 32'd0 &&
        (wake_injector == WAKE_V || wake_injector == WAKE_H))
        else $error("bad wake result");

    // A taken pending sum never comes with a swallow or a report
    a_take_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && pending_delta != 32'd0 |-> !swallow && !report_valid)
        else $error("take result carries event fields");

endmodule

bind mouse_event_filter mef_checker u_mef_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .swallow        (result.swallow),
    .report_valid   (result.report_valid),
    .ev_code        (result.ev_code),
    .report_blocked (result.report_blocked),
    .wake_injector  (result.wake_injector),
    .pending_delta  (result.pending_delta)
);

`default_nettype wire

// ===== tb/mouse_event_filter_tb.sv =====
// Self-checking testbench for the mouse event filter: directed and random traffic.
`timescale 1ns / 1ps

module mouse_event_filter_tb;
    import mef_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mef_item_if   mouse_ch ();
    mef_result_if result_ch ();
    mef_cfg_if    cfg_ch ();

    mouse_event_filter i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .mouse  (mouse_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Shadow configuration, updated as each register write is accepted
    logic [3:0]  cf_flags    = 4'd0;
    logic [8:0]  cf_interest = 9'd0;
    logic [8:0]  cf_block    = 9'd0;
    logic        cf_v_ready  = 1'b0;
    logic        cf_h_ready  = 1'b0;
    logic [15:0] cf_window   = RECENT_WINDOW_RESET;

    // Shadow filter state
    logic [2:0]  sh_held      = 3'd0;
    logic [31:0] sh_pend_v    = 32'd0;
    logic [31:0] sh_pend_h    = 32'd0;
    logic        sh_posted_v  = 1'b0;
    logic        sh_posted_h  = 1'b0;
    logic        sh_mark_ok   = 1'b0;
    logic [31:0] sh_mark_at   = 32'd0;

    mef_item_t   event_backlog[$];
    mef_result_t awaited_verdicts[$];
    mef_item_t   offered_event;
    mef_item_t   next_event;
    mef_result_t seen_result;

    int          mismatches = 0;
    int          queued = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic [31:0] tick = 32'd0;
    logic        backpressure_kick = 1'b0;
    int          backpressure_left;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fold a wheel delta into the pending sum of one axis; 1 when swallowed
    function automatic logic wheel_invert(input logic vert, input logic signed [31:0] delta,
                                          input logic post_ok, output logic [1:0] wake);
        wake = WAKE_NONE;
        if (delta == 0 || !(vert ? cf_v_ready : cf_h_ready))
            return 1'b0;
        if (!(vert ? sh_posted_v : sh_posted_h) && !post_ok)
            return 1'b0;
        if (vert)
            sh_pend_v = sh_pend_v - delta;
        else
            sh_pend_h = sh_pend_h - delta;
        if (!(vert ? sh_posted_v : sh_posted_h))
        begin
            if (vert)
                sh_posted_v = 1'b1;
            else
                sh_posted_h = 1'b1;
            wake = vert ? WAKE_V : WAKE_H;
        end
        return 1'b1;
    endfunction

    function automatic mef_result_t with_report(mef_result_t r, mef_item_t it,
                                                logic [3:0] code, logic blk);
        r.report_valid   = 1'b1;
        r.ev_code        = code;
        r.report_blocked = blk;
        r.report_message = it.message_type;
        r.report_data    = it.msg_data;
        r.report_flags   = it.hook_flags;
        r.report_extra   = it.opaque_word;
        return r;
    endfunction

    // Track swallowed presses so that a release is swallowed only after its press
    function automatic logic pair_swallow(logic [3:0] code, logic blk);
        logic [2:0] held_bit;
        logic       was_held;
        held_bit = 3'd1 << ((code - 4'd1) >> 1);
        case (code)
            EV_X1_DOWN, EV_X2_DOWN, EV_MID_DOWN:
            begin
                if (blk)
                    sh_held = sh_held | held_bit;
                return blk;
            end
            EV_X1_UP, EV_X2_UP, EV_MID_UP:
            begin
                was_held = (sh_held & held_bit) != 3'd0;
                sh_held = sh_held & ~held_bit;
                return blk && was_held;
            end
            default: return blk;
        endcase
    endfunction

    function automatic mef_result_t filter_verdict(mef_item_t it);
        mef_result_t        r;
        logic signed [31:0] delta;
        logic [31:0]        age;
        logic               is_recent;
        logic               intercept;
        logic               vinv;
        logic               hinv;
        logic               debug;
        logic [3:0]         code;
        logic               blk;
        logic [1:0]         wake;
        r = '0;
        delta = {{16{it.msg_data[31]}}, it.msg_data[31:16]};
        age = it.now_ms - sh_mark_at;
        is_recent = sh_mark_ok && (age <= {16'd0, cf_window});
        intercept = cf_flags[FLAG_INTERCEPT];
        vinv = cf_flags[FLAG_VINV];
        hinv = cf_flags[FLAG_HINV];
        debug = cf_flags[FLAG_DEBUG];

        // Non-mouse kinds: mark the wheel time or take a pending sum
        case (it.kind)
            KIND_MARK:
            begin
                sh_mark_ok = 1'b1;
                sh_mark_at = it.now_ms;
                return r;
            end
            KIND_TAKE_V:
            begin
                r.pending_delta = sh_pend_v;
                sh_pend_v = 32'd0;
                sh_posted_v = 1'b0;
                return r;
            end
            KIND_TAKE_H:
            begin
                r.pending_delta = sh_pend_h;
                sh_pend_h = 32'd0;
                sh_posted_h = 1'b0;
                return r;
            end
            default: ;
        endcase

        if (it.message_type == MSG_MOVE)
            return r;
        if ((it.message_type == MSG_WHEEL || it.message_type == MSG_HWHEEL) &&
            !(vinv || hinv || (intercept && (cf_interest[7] || cf_interest[8]))) && !debug)
            return r;
        if (it.hook_flags[0])
            return r;

        // Pass-through mode: only wheel inversion can swallow
        if (!intercept)
        begin
            if (it.message_type == MSG_WHEEL && vinv && is_recent)
            begin
                if (wheel_invert(1'b1, delta, it.post_ok, wake))
                begin
                    r.swallow = 1'b1;
                    r.wake_injector = wake;
                    return r;
                end
            end
            else if (it.message_type == MSG_HWHEEL && hinv && is_recent)
            begin
                if (wheel_invert(1'b0, delta, it.post_ok, wake))
                begin
                    r.swallow = 1'b1;
                    r.wake_injector = wake;
                    return r;
                end
            end
            if (debug)
                r = with_report(r, it, EV_NONE, 1'b0);
            return r;
        end

        // Classify the message into an event code
        case (it.message_type)
            MSG_XDOWN:    code = (delta == 1) ? EV_X1_DOWN : ((delta == 2) ? EV_X2_DOWN : EV_NONE);
            MSG_XUP:      code = (delta == 1) ? EV_X1_UP : ((delta == 2) ? EV_X2_UP : EV_NONE);
            MSG_MID_DOWN: code = EV_MID_DOWN;
            MSG_MID_UP:   code = EV_MID_UP;
            MSG_HWHEEL:   code = (delta > 0) ? EV_SCROLL_LEFT :
                                 ((delta < 0) ? EV_SCROLL_RIGHT : EV_NONE);
            default:      code = EV_NONE;
        endcase

        if (it.message_type == MSG_WHEEL)
        begin
            if (vinv && is_recent)
            begin
                if (wheel_invert(1'b1, delta, it.post_ok, wake))
                begin
                    r.swallow = 1'b1;
                    r.wake_injector = wake;
                    return r;
                end
            end
            if (debug)
                r = with_report(r, it, EV_NONE, 1'b0);
            return r;
        end

        blk = (code != EV_NONE) && cf_block[code];

        // An unblocked horizontal scroll may still be inverted
        if (it.message_type == MSG_HWHEEL && !blk && hinv && is_recent)
        begin
            if (wheel_invert(1'b0, delta, it.post_ok, wake))
            begin
                r.swallow = 1'b1;
                r.wake_injector = wake;
                return r;
            end
        end

        if (code == EV_NONE)
        begin
            if (debug)
                r = with_report(r, it, EV_NONE, 1'b0);
            return r;
        end

        blk = pair_swallow(code, blk);
        if (cf_interest[code] || debug)
            r = with_report(r, it, code, blk);
        r.swallow = blk;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, pressure counter, driver and monitor
    // ------------------------------------------------------------------

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold the result channel off for a long stretch when kicked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            backpressure_left <= 0;
        else if (backpressure_kick)
            backpressure_left <= 200;
        else if (backpressure_left != 0)
            backpressure_left <= backpressure_left - 1;
    end

    // Drive mouse items; predict each one as its transaction completes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mouse_ch.valid <= 1'b0;
        else
        begin
            if (mouse_ch.valid && mouse_ch.ready)
                awaited_verdicts.push_back(filter_verdict(offered_event));
            if (!mouse_ch.valid || mouse_ch.ready)
            begin
                if (event_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_event = event_backlog.pop_front();
                    offered_event = next_event;
                    mouse_ch.valid        <= 1'b1;
                    mouse_ch.kind         <= next_event.kind;
                    mouse_ch.message_type <= next_event.message_type;
                    mouse_ch.msg_data     <= next_event.msg_data;
                    mouse_ch.hook_flags   <= next_event.hook_flags;
                    mouse_ch.opaque_word  <= next_event.opaque_word;
                    mouse_ch.now_ms       <= next_event.now_ms;
                    mouse_ch.post_ok      <= next_event.post_ok;
                end
                else
                    mouse_ch.valid <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task automatic compare_verdict(mef_result_t got, mef_result_t want);
        if (got.swallow !== want.swallow)
            note_mismatch("swallow", got.swallow, want.swallow);
        if (got.report_valid !== want.report_valid)
            note_mismatch("report_valid", got.report_valid, want.report_valid);
        if (got.ev_code !== want.ev_code)
            note_mismatch("ev_code", got.ev_code, want.ev_code);
        if (got.report_blocked !== want.report_blocked)
            note_mismatch("report_blocked", got.report_blocked, want.report_blocked);
        if (got.report_message !== want.report_message)
            note_mismatch("report_message", got.report_message, want.report_message);
        if (got.report_data !== want.report_data)
            note_mismatch("report_data", got.report_data, want.report_data);
        if (got.report_flags !== want.report_flags)
            note_mismatch("report_flags", got.report_flags, want.report_flags);
        if (got.report_extra !== want.report_extra)
            note_mismatch("report_extra", got.report_extra, want.report_extra);
        if (got.wake_injector !== want.wake_injector)
            note_mismatch("wake_injector", got.wake_injector, want.wake_injector);
        if (got.pending_delta !== want.pending_delta)
            note_mismatch("pending_delta", got.pending_delta, want.pending_delta);
    endtask

    // Check each accepted result against the oldest prediction; drive ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen_result.swallow        = result_ch.swallow;
                seen_result.report_valid   = result_ch.report_valid;
                seen_result.ev_code        = result_ch.ev_code;
                seen_result.report_blocked = result_ch.report_blocked;
                seen_result.report_message = result_ch.report_message;
                seen_result.report_data    = result_ch.report_data;
                seen_result.report_flags   = result_ch.report_flags;
                seen_result.report_extra   = result_ch.report_extra;
                seen_result.wake_injector  = result_ch.wake_injector;
                seen_result.pending_delta  = result_ch.pending_delta;
                if (awaited_verdicts.size() == 0)
                    note_mismatch("unexpected result", 64'd0, 64'd0);
                else
                    compare_verdict(seen_result, awaited_verdicts.pop_front());
            end
            result_ch.ready <= (backpressure_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [15:0] wheel_delta();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'd120;
            2: return 16'hFF88;
            3: return 16'h7FFF;
            4: return 16'h8000;
            5: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] button_number();
        case ($urandom_range(0, 5))
            0, 1, 2: return 16'd1;
            3, 4:    return 16'd2;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic mef_item_t shaped_event(logic [1:0] kind, logic [2:0] msg,
                                               logic [15:0] hi, logic post, logic injected);
        mef_item_t it;
        it.kind         = kind;
        it.message_type = msg;
        it.msg_data     = {hi, 16'($urandom_range(0, 65535))};
        it.hook_flags   = $urandom;
        it.hook_flags[0] = injected;
        it.opaque_word  = {$urandom, $urandom};
        it.now_ms       = tick;
        it.post_ok      = post;
        return it;
    endfunction

    task automatic enqueue_item(logic [1:0] kind, logic [2:0] msg, logic [15:0] hi);
        event_backlog.push_back(shaped_event(kind, msg, hi, $urandom_range(0, 4) != 0,
                                             $urandom_range(0, 9) == 0));
        queued++;
    endtask

    // Advance the stimulus tick: small steps inside a wheel burst, jumps otherwise
    task automatic advance_tick(logic wide);
        if (wide && $urandom_range(0, 19) == 0)
            tick = $urandom;
        else if (wide)
            tick = tick + $urandom_range(0, 500);
        else if ($urandom_range(0, 3) != 0)
            tick = tick + $urandom_range(1, 60);
    endtask

    task automatic random_burst();
        logic [15:0] btn;
        logic        use_mid;
        case ($urandom_range(0, 9))
            // Mark the wheel, roll it a few times, then take the sums
            0, 1, 2, 3:
            begin
                advance_tick(1'b1);
                enqueue_item(KIND_MARK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
                repeat ($urandom_range(1, 5))
                begin
                    advance_tick(1'b0);
                    enqueue_item(KIND_MOUSE, $urandom_range(0, 1) ? MSG_WHEEL : MSG_HWHEEL,
                                 wheel_delta());
                end
                if ($urandom_range(0, 2) != 0)
                    enqueue_item(KIND_TAKE_V, 3'($urandom_range(0, 7)),
                                 16'($urandom_range(0, 65535)));
                if ($urandom_range(0, 2) != 0)
                    enqueue_item(KIND_TAKE_H, 3'($urandom_range(0, 7)),
                                 16'($urandom_range(0, 65535)));
            end
            // Press and release of one button, sometimes with noise between
            4, 5, 6:
            begin
                btn = button_number();
                use_mid = $urandom_range(0, 2) == 0;
                advance_tick(1'b1);
                enqueue_item(KIND_MOUSE, use_mid ? MSG_MID_DOWN : MSG_XDOWN, btn);
                if ($urandom_range(0, 2) == 0)
                    enqueue_item(KIND_MOUSE, 3'($urandom_range(0, 7)), wheel_delta());
                advance_tick(1'b0);
                enqueue_item(KIND_MOUSE, use_mid ? MSG_MID_UP : MSG_XUP, btn);
            end
            // Single item of any kind
            default:
            begin
                advance_tick(1'b1);
                enqueue_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                             $urandom_range(0, 1) ? wheel_delta() : button_number());
            end
        endcase
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_FILTER_FLAGS:   cf_flags    = value[3:0];
            CFG_INTEREST_MASK:  cf_interest = value[8:0];
            CFG_BLOCK_MASK:     cf_block    = value[8:0];
            CFG_INJECT_V_READY: cf_v_ready  = value[0];
            CFG_INJECT_H_READY: cf_h_ready  = value[0];
            CFG_RECENT_WINDOW:  cf_window   = value;
            default: ;
        endcase
    endtask

    // Wait until every item is sent and every result is back, then settle
    task automatic wait_quiet();
        while (event_backlog.size() != 0 || mouse_ch.valid || awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(logic [3:0] flags, logic [8:0] interest, logic [8:0] blockm,
                             logic v_ready, logic h_ready, logic [15:0] window,
                             int send_idle, int stall, int count, logic squeeze);
        int target;
        wait_quiet();
        write_reg(CFG_FILTER_FLAGS, {12'd0, flags});
        write_reg(CFG_INTEREST_MASK, {7'd0, interest});
        write_reg(CFG_BLOCK_MASK, {7'd0, blockm});
        write_reg(CFG_INJECT_V_READY, {15'd0, v_ready});
        write_reg(CFG_INJECT_H_READY, {15'd0, h_ready});
        write_reg(CFG_RECENT_WINDOW, window);
        cfg_ch.valid <= 1'b0;
        send_idle_pct = send_idle;
        stall_pct = stall;
        target = queued + count;
        while (queued < target)
            random_burst();
        if (squeeze)
        begin
            @(posedge clk);
            backpressure_kick <= 1'b1;
            @(posedge clk);
            backpressure_kick <= 1'b0;
        end
    endtask

    // Fixed opening sequence: every message, both buttons, wrap of the tick
    task automatic directed_checks();
        mef_item_t it;
        tick = 32'hFFFF_FFF0;
        enqueue_item(KIND_MOUSE, MSG_MOVE, 16'd0);
        it = shaped_event(KIND_MOUSE, MSG_OTHER, 16'hFFFF, 1'b1, 1'b0);
        it.msg_data = 32'hFFFF_FFFF;
        event_backlog.push_back(it);
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_XDOWN, 16'd1, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_XUP, 16'd1, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_XDOWN, 16'd2, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_XUP, 16'd2, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_XDOWN, 16'd3, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_MID_DOWN, 16'd0, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_MID_UP, 16'd0, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_XDOWN, 16'd1, 1'b1, 1'b1));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_HWHEEL, 16'd120, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_HWHEEL, 16'hFF88, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_HWHEEL, 16'd0, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_WHEEL, 16'd0, 1'b1, 1'b0));
        // Mark just before the tick wraps, then roll the wheel after the wrap
        event_backlog.push_back(shaped_event(KIND_MARK, MSG_MOVE, 16'd0, 1'b1, 1'b0));
        tick = 32'h0000_0010;
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_WHEEL, 16'd120, 1'b1, 1'b0));
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_WHEEL, 16'h8000, 1'b0, 1'b0));
        event_backlog.push_back(shaped_event(KIND_TAKE_V, MSG_OTHER, 16'hFFFF, 1'b1, 1'b0));
        // Wake refused: nothing outstanding and the injector does not take it
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_WHEEL, 16'd120, 1'b0, 1'b0));
        event_backlog.push_back(shaped_event(KIND_TAKE_H, MSG_MOVE, 16'd0, 1'b1, 1'b0));
        tick = 32'hFFFF_FFFF;
        it = shaped_event(KIND_MOUSE, MSG_XUP, 16'd0, 1'b1, 1'b0);
        it.msg_data = 32'd0;
        it.hook_flags = 32'hFFFF_FFFE;
        it.opaque_word = 64'hFFFF_FFFF_FFFF_FFFF;
        event_backlog.push_back(it);
        // Mark, then a wheel one past the window
        tick = 32'h0001_0000;
        event_backlog.push_back(shaped_event(KIND_MARK, MSG_WHEEL, 16'd0, 1'b1, 1'b0));
        tick = 32'h0001_0051;
        event_backlog.push_back(shaped_event(KIND_MOUSE, MSG_WHEEL, 16'd120, 1'b1, 1'b0));
        it = shaped_event(KIND_TAKE_V, MSG_OTHER, 16'hFFFF, 1'b0, 1'b1);
        it.opaque_word = 64'd0;
        event_backlog.push_back(it);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        mouse_ch.valid        = 1'b0;
        mouse_ch.kind         = KIND_MOUSE;
        mouse_ch.message_type = MSG_MOVE;
        mouse_ch.msg_data     = 32'd0;
        mouse_ch.hook_flags   = 32'd0;
        mouse_ch.opaque_word  = 64'd0;
        mouse_ch.now_ms       = 32'd0;
        mouse_ch.post_ok      = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_FILTER_FLAGS;
        cfg_ch.data           = 16'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part keeps the window at its reset value
        write_reg(CFG_FILTER_FLAGS, 16'h000F);
        write_reg(CFG_INTEREST_MASK, 16'h01FF);
        write_reg(CFG_BLOCK_MASK, 16'h01FF);
        write_reg(CFG_INJECT_V_READY, 16'd1);
        write_reg(CFG_INJECT_H_READY, 16'd1);
        cfg_ch.valid <= 1'b0;
        directed_checks();

        run_phase(4'b0110, 9'h000, 9'h000, 1'b1, 1'b1, 16'd80, 0, 0, 70, 1'b1);
        run_phase(4'b1111, 9'h1FF, 9'h1FF, 1'b1, 1'b1, 16'hFFFF, 85, 0, 70, 1'b0);
        run_phase(4'b0001, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                  1'b0, 1'b1, 16'd0, 0, 85, 70, 1'b0);
        run_phase(4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)),
                  9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(0, 300)), 29, 29, 70, 1'b0);
        run_phase(4'b1000, 9'h000, 9'h000, 1'b1, 1'b0, 16'd200, 0, 0, 70, 1'b0);
        run_phase(4'b0111, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                  1'b1, 1'b1, 16'd150, 29, 29, 75, 1'b0);
        wait_quiet();

        if (mismatches == 0)
            $display("** mouse_event_filter: PASSED **");
        else
            $display("** mouse_event_filter: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("** mouse_event_filter: FAILED **");
        $finish;
    end

endmodule
